// ===== design/frt_pkg.sv =====
// Package: constants, codes and item types of the fragment reassembly tracker
`timescale 1ns / 1ps
package frt_pkg;

    localparam int TABLE_SLOTS    = 16;
    localparam int PER_PEER_LIMIT = 4;
    localparam int FRAGMENT_LIMIT = 64;
    localparam int SLOT_W         = $clog2(TABLE_SLOTS);
    localparam int CNT_W          = $clog2(TABLE_SLOTS + 1);
    localparam int SIZE_W         = 24;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 24'd65536;

    localparam logic [1:0] ACT_PACKET     = 2'd0;
    localparam logic [1:0] ACT_FORGET     = 2'd1;
    localparam logic [1:0] ACT_FORGET_ALL = 2'd2;
    localparam logic [1:0] ACT_RESERVED   = 2'd3;

    typedef enum logic [3:0] {
        VD_WHOLE      = 4'd0,
        VD_OVERSIZE   = 4'd1,
        VD_SEQ_LOW    = 4'd2,
        VD_INCONSIST  = 4'd3,
        VD_DUPLICATE  = 4'd4,
        VD_OVER_LIMIT = 4'd5,
        VD_PENDING    = 4'd6,
        VD_COMPLETED  = 4'd7,
        VD_BAD_INDEX  = 4'd8,
        VD_NO_SLOT    = 4'd9,
        VD_CLEARED    = 4'd10
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] peer_key;
        logic        is_fragmented;
        logic [7:0]  channel;
        logic [31:0] sequence_number;
        logic [5:0]  fragment_index;
        logic [6:0]  fragment_count;
        logic [15:0] body_length;
    } pkt_item_t;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [3:0]  slot;
        logic [7:0]  out_channel;
        logic [23:0] message_length;
        logic [31:0] first_sequence;
        logic        evicted;
        logic [3:0]  evicted_slot;
        logic [2:0]  peer_partials;
    } res_item_t;

endpackage

// ===== design/fragment_reassembly_tracker.sv =====
// Top level: slot table of partial messages with a one-slot-per-cycle scan sequencer
// A command or an unfragmented packet gets its result in the decide state after a scan of
// every slot; a fragment that passes the decide state gets its result in the check state.
// The serial slot scan runs for every item; no new item is taken before the last is done.
// The next item is taken once the previous result has been taken.
// Reset clears all slot valid bits at once and sets max_message_size to 65536.
`timescale 1ns / 1ps
module fragment_reassembly_tracker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    output logic              pkt_ready,
    input  frt_pkg::pkt_item_t pkt,
    output logic              res_valid,
    input  logic              res_ready,
    output frt_pkg::res_item_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [23:0]       cfg_data
);
    import frt_pkg::*;

    state_t state_reg, state_next;
    pkt_item_t req_reg, req_next;
    res_item_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;
    logic [SIZE_W-1:0] max_size_reg;
    logic [31:0] fs_reg, fs_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] found_reg, found_next, free_reg, free_next;
    logic [SLOT_W-1:0] old_reg, old_next, slot_reg, slot_next;
    logic found_hit_reg, found_hit_next, free_hit_reg, free_hit_next;
    logic old_hit_reg, old_hit_next;
    logic [31:0] old_seq_reg, old_seq_next;
    logic ev_reg, ev_next;

    logic [TABLE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [47:0] slot_peer [TABLE_SLOTS];
    logic [31:0] slot_first_seq [TABLE_SLOTS];
    logic [7:0]  slot_channel [TABLE_SLOTS];
    logic [6:0]  slot_frag_count [TABLE_SLOTS];
    logic [63:0] slot_present [TABLE_SLOTS];
    logic [23:0] slot_total [TABLE_SLOTS];
    logic [6:0]  slot_received [TABLE_SLOTS];

    logic [SLOT_W-1:0] rd;
    logic rd_peer_eq, rd_fs_eq;
    logic alloc_we, upd_we;
    logic [SLOT_W-1:0] wr_slot;
    logic [63:0] upd_present;
    logic [23:0] upd_total;
    logic [6:0]  upd_received;
    logic [24:0] sum;
    logic pkt_acc;
    logic [CNT_W-1:0] cnt_tmp;
    logic [SLOT_W-1:0] pick;

    function automatic logic [2:0] sat3(input logic [CNT_W-1:0] n);
        sat3 = (n > CNT_W'(7)) ? 3'd7 : n[2:0];
    endfunction

    assign pkt_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign pkt_acc   = pkt_valid && pkt_ready;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign rd         = (state_reg == ST_SCAN) ? idx_reg : slot_reg;
    assign rd_peer_eq = slot_peer[rd] == req_reg.peer_key;
    assign rd_fs_eq   = slot_first_seq[rd] == fs_reg;
    assign sum        = {1'b0, slot_total[rd]} + {9'd0, req_reg.body_length};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_acc)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == SLOT_W'(TABLE_SLOTS - 1))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (req_reg.action == ACT_PACKET && req_reg.is_fragmented
                    && req_reg.sequence_number >= {26'd0, req_reg.fragment_index}
                    && req_reg.fragment_count != 7'd0
                    && req_reg.fragment_count <= 7'(FRAGMENT_LIMIT)
                    && {1'b0, req_reg.fragment_index} < req_reg.fragment_count)
                begin
                    if (found_hit_reg || free_hit_reg
                        || (cnt_reg >= CNT_W'(PER_PEER_LIMIT) && old_hit_reg))
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_next        = req_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        fs_next         = fs_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        found_hit_next  = found_hit_reg;
        free_next       = free_reg;
        free_hit_next   = free_hit_reg;
        old_next        = old_reg;
        old_hit_next    = old_hit_reg;
        old_seq_next    = old_seq_reg;
        slot_next       = slot_reg;
        ev_next         = ev_reg;
        slot_valid_next = slot_valid_reg;
        alloc_we        = 1'b0;
        upd_we          = 1'b0;
        wr_slot         = slot_reg;
        upd_present     = slot_present[rd] | (64'd1 << req_reg.fragment_index);
        upd_total       = sum[23:0];
        upd_received    = slot_received[rd] + 7'd1;
        cnt_tmp         = cnt_reg;
        pick            = free_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_acc)
                begin
                    req_next       = pkt;
                    fs_next        = pkt.sequence_number - {26'd0, pkt.fragment_index};
                    idx_next       = '0;
                    cnt_next       = '0;
                    found_hit_next = 1'b0;
                    free_hit_next  = 1'b0;
                    old_hit_next   = 1'b0;
                    ev_next        = 1'b0;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + SLOT_W'(1);
                if (req_reg.action == ACT_FORGET_ALL
                    || (req_reg.action == ACT_FORGET && rd_peer_eq))
                    slot_valid_next[idx_reg] = 1'b0;
                if (slot_valid_reg[idx_reg] && rd_peer_eq)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (rd_fs_eq && !found_hit_reg)
                    begin
                        found_next     = idx_reg;
                        found_hit_next = 1'b1;
                    end
                    if (!old_hit_reg || slot_first_seq[rd] < old_seq_reg)
                    begin
                        old_next     = idx_reg;
                        old_seq_next = slot_first_seq[rd];
                        old_hit_next = 1'b1;
                    end
                end
                if (!slot_valid_reg[idx_reg] && !free_hit_reg)
                begin
                    free_next     = idx_reg;
                    free_hit_next = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                res_next = '0;
                res_next.peer_partials = sat3(cnt_reg);
                if (req_reg.action != ACT_PACKET)
                begin
                    res_next.verdict = VD_CLEARED;
                    if (req_reg.action == ACT_FORGET || req_reg.action == ACT_FORGET_ALL)
                        res_next.peer_partials = 3'd0;
                    res_valid_next = 1'b1;
                end
                else if (!req_reg.is_fragmented)
                begin
                    if ({8'd0, req_reg.body_length} > max_size_reg)
                        res_next.verdict = VD_OVERSIZE;
                    else
                    begin
                        res_next.verdict        = VD_WHOLE;
                        res_next.out_channel    = req_reg.channel;
                        res_next.message_length = {8'd0, req_reg.body_length};
                    end
                    res_valid_next = 1'b1;
                end
                else if (req_reg.sequence_number < {26'd0, req_reg.fragment_index})
                begin
                    res_next.verdict = VD_SEQ_LOW;
                    res_valid_next   = 1'b1;
                end
                else if (state_next != ST_CHECK && !(found_hit_reg || free_hit_reg
                         || (cnt_reg >= CNT_W'(PER_PEER_LIMIT) && old_hit_reg))
                         && !(req_reg.fragment_count == 7'd0
                         || req_reg.fragment_count > 7'(FRAGMENT_LIMIT)
                         || {1'b0, req_reg.fragment_index} >= req_reg.fragment_count))
                begin
                    // no slot free and nothing to evict
                    res_next.verdict        = VD_NO_SLOT;
                    res_next.first_sequence = fs_reg;
                    res_valid_next          = 1'b1;
                end
                else if (state_next != ST_CHECK)
                begin
                    res_next.verdict        = VD_BAD_INDEX;
                    res_next.first_sequence = fs_reg;
                    res_valid_next          = 1'b1;
                end
                else if (found_hit_reg)
                    slot_next = found_reg;
                else
                begin
                    if (cnt_reg >= CNT_W'(PER_PEER_LIMIT))
                    begin
                        ev_next                  = 1'b1;
                        slot_valid_next[old_reg] = 1'b0;
                        cnt_tmp                  = cnt_reg - CNT_W'(1);
                        if (!free_hit_reg || old_reg < free_reg)
                            pick = old_reg;
                    end
                    slot_next             = pick;
                    wr_slot               = pick;
                    alloc_we              = 1'b1;
                    slot_valid_next[pick] = 1'b1;
                    cnt_next              = cnt_tmp + CNT_W'(1);
                end
            end
            ST_CHECK:
            begin
                res_next                = '0;
                res_next.slot           = 4'(slot_reg);
                res_next.first_sequence = fs_reg;
                res_next.evicted        = ev_reg;
                res_next.evicted_slot   = ev_reg ? 4'(old_reg) : 4'd0;
                cnt_tmp                 = cnt_reg;
                if (slot_frag_count[rd] != req_reg.fragment_count
                    || slot_channel[rd] != req_reg.channel)
                begin
                    res_next.verdict          = VD_INCONSIST;
                    slot_valid_next[slot_reg] = 1'b0;
                    cnt_tmp                   = cnt_reg - CNT_W'(1);
                end
                else if (slot_present[rd][req_reg.fragment_index])
                    res_next.verdict = VD_DUPLICATE;
                else if (sum > {1'b0, max_size_reg})
                begin
                    res_next.verdict          = VD_OVER_LIMIT;
                    slot_valid_next[slot_reg] = 1'b0;
                    cnt_tmp                   = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    upd_we = 1'b1;
                    if (upd_received < slot_frag_count[rd])
                        res_next.verdict = VD_PENDING;
                    else
                    begin
                        res_next.verdict          = VD_COMPLETED;
                        res_next.out_channel      = slot_channel[rd];
                        res_next.message_length   = upd_total;
                        slot_valid_next[slot_reg] = 1'b0;
                        cnt_tmp                   = cnt_reg - CNT_W'(1);
                    end
                end
                res_next.peer_partials = sat3(cnt_tmp);
                res_valid_next         = 1'b1;
            end
            default:
            begin
                res_valid_next = res_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            max_size_reg   <= MAX_SIZE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            slot_valid_reg <= slot_valid_next;
            if (cfg_valid && cfg_ready)
                max_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        fs_reg        <= fs_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        found_reg     <= found_next;
        found_hit_reg <= found_hit_next;
        free_reg      <= free_next;
        free_hit_reg  <= free_hit_next;
        old_reg       <= old_next;
        old_hit_reg   <= old_hit_next;
        old_seq_reg   <= old_seq_next;
        slot_reg      <= slot_next;
        ev_reg        <= ev_next;
    end

    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            slot_peer[wr_slot]       <= req_reg.peer_key;
            slot_first_seq[wr_slot]  <= fs_reg;
            slot_channel[wr_slot]    <= req_reg.channel;
            slot_frag_count[wr_slot] <= req_reg.fragment_count;
            slot_present[wr_slot]    <= '0;
            slot_total[wr_slot]      <= '0;
            slot_received[wr_slot]   <= '0;
        end
        else if (upd_we)
        begin
            slot_present[wr_slot]  <= upd_present;
            slot_total[wr_slot]    <= upd_total;
            slot_received[wr_slot] <= upd_received;
        end
    end

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && req_reg.action == ACT_FORGET_ALL)
        |-> slot_valid_reg == '0)
        else $error("forget-all left a valid slot");

    a_check_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> slot_valid_reg[slot_reg])
        else $error("checking an invalid slot");

    a_evict_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.evicted) |-> res_reg.evicted_slot == 4'd0)
        else $error("evicted slot without eviction");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pkt_ready)
        else $error("item taken while busy");

endmodule
